// File: rtl/tcsb_pkg.sv
// Shared types and constants for the TCP control segment builder.
// Used by the front pipeline, the header queue, the word serializer and the top level.
`default_nettype none

package tcsb_pkg;

    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 32;

    localparam int HDR_WORDS = 10;
    localparam int IDX_W     = $clog2(HDR_WORDS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SUM_W = 20;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIN   = 2'd1,
        KIND_RST   = 2'd2,
        KIND_PLAIN = 2'd3
    } kind_t;

    localparam logic [7:0]  FLAG_FIN   = 8'h01;
    localparam logic [7:0]  FLAG_RST   = 8'h04;
    localparam logic [7:0]  FLAG_ACK   = 8'h10;
    localparam logic [7:0]  FLAG_NONE  = 8'h00;
    localparam logic [15:0] FIN_WINDOW = 16'd6567;

    localparam logic [7:0]  VER_IHL    = 8'h45;
    localparam logic [15:0] TOTAL_LEN  = 16'd40;
    localparam logic [7:0]  TTL_VALUE  = 8'hff;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [15:0] TCP_LEN    = 16'd20;
    localparam logic [7:0]  DATA_OFS   = 8'h50;

    // constant halves folded into the checksum sums
    localparam logic [SUM_W-1:0] IP_CONST_SUM =
        SUM_W'({VER_IHL, 8'h00}) + SUM_W'(TOTAL_LEN) + SUM_W'({TTL_VALUE, PROTO_TCP});
    localparam logic [SUM_W-1:0] TCP_CONST_SUM =
        SUM_W'(PROTO_TCP) + SUM_W'(TCP_LEN) + SUM_W'({DATA_OFS, 8'h00});

    typedef struct packed {
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_tcp_port;
        logic [15:0] dest_tcp_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] ip_ident;
    } req_t;

    typedef struct packed {
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_tcp_port;
        logic [15:0] dest_tcp_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] ip_ident;
        logic [7:0]  flags;
        logic [15:0] window;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } hdr_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/tcsb_front.sv
// Front pipeline: takes requests, decodes the segment kind and builds both checksums.
// Two register stages; depends on tcsb_pkg.
`default_nettype none

module tcsb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_kind,
    input  wire tcsb_pkg::req_t s_req,
    output logic               push_valid,
    input  wire logic          push_ready,
    output tcsb_pkg::hdr_t     push_data
);

    logic                        s1_valid_reg, s1_valid_next;
    tcsb_pkg::hdr_t              s1_hdr_reg, s1_hdr_next;
    logic [17:0]                 s1_addr_sum_reg, s1_addr_sum_next;
    logic [18:0]                 s1_tcp_part_reg, s1_tcp_part_next;

    logic                        s2_valid_reg, s2_valid_next;
    tcsb_pkg::hdr_t              s2_hdr_reg, s2_hdr_next;
    logic [tcsb_pkg::SUM_W-1:0]  s2_ip_sum_reg, s2_ip_sum_next;
    logic [tcsb_pkg::SUM_W-1:0]  s2_tcp_sum_reg, s2_tcp_sum_next;

    logic s1_adv;
    logic s2_adv;

    function automatic logic [15:0] fold_csum(input logic [tcsb_pkg::SUM_W-1:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = 17'(s[tcsb_pkg::SUM_W-1:16]) + 17'(s[15:0]);
        f2 = 17'(f1[16]) + 17'(f1[15:0]);
        return ~f2[15:0];
    endfunction

    assign s2_adv  = !s2_valid_reg || push_ready;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign s_ready = s1_adv;

    // stage 1: kind decode and partial sums
    always_comb
    begin
        s1_hdr_next.source_addr     = s_req.source_addr;
        s1_hdr_next.dest_addr       = s_req.dest_addr;
        s1_hdr_next.source_tcp_port = s_req.source_tcp_port;
        s1_hdr_next.dest_tcp_port   = s_req.dest_tcp_port;
        s1_hdr_next.seq_number      = s_req.seq_number;
        s1_hdr_next.ack_number      = s_req.ack_number;
        s1_hdr_next.ip_ident        = s_req.ip_ident;
        s1_hdr_next.flags           = tcsb_pkg::FLAG_NONE;
        s1_hdr_next.window          = 16'd0;
        s1_hdr_next.ip_csum         = 16'd0;
        s1_hdr_next.tcp_csum        = 16'd0;
        case (tcsb_pkg::kind_t'(s_kind))
            tcsb_pkg::KIND_ACK:
            begin
                s1_hdr_next.flags = tcsb_pkg::FLAG_ACK;
            end
            tcsb_pkg::KIND_FIN:
            begin
                s1_hdr_next.flags  = tcsb_pkg::FLAG_FIN | tcsb_pkg::FLAG_ACK;
                s1_hdr_next.window = tcsb_pkg::FIN_WINDOW;
            end
            tcsb_pkg::KIND_RST:
            begin
                s1_hdr_next.flags      = tcsb_pkg::FLAG_RST;
                s1_hdr_next.ack_number = 32'd0;
            end
            default:
            begin
                s1_hdr_next.flags = tcsb_pkg::FLAG_NONE;
            end
        endcase

        s1_addr_sum_next = 18'(s_req.source_addr[31:16]) + 18'(s_req.source_addr[15:0])
                         + 18'(s_req.dest_addr[31:16]) + 18'(s_req.dest_addr[15:0]);
        s1_tcp_part_next = 19'(s_req.source_tcp_port) + 19'(s_req.dest_tcp_port)
                         + 19'(s_req.seq_number[31:16]) + 19'(s_req.seq_number[15:0])
                         + 19'(s1_hdr_next.ack_number[31:16])
                         + 19'(s1_hdr_next.ack_number[15:0])
                         + 19'(s1_hdr_next.flags) + 19'(s1_hdr_next.window);
        s1_valid_next = s1_adv ? s_valid : s1_valid_reg;
    end

    // stage 2: full sums
    always_comb
    begin
        s2_hdr_next     = s1_hdr_reg;
        s2_ip_sum_next  = tcsb_pkg::SUM_W'(s1_addr_sum_reg) + tcsb_pkg::SUM_W'(s1_hdr_reg.ip_ident)
                        + tcsb_pkg::IP_CONST_SUM;
        s2_tcp_sum_next = tcsb_pkg::SUM_W'(s1_addr_sum_reg) + tcsb_pkg::SUM_W'(s1_tcp_part_reg)
                        + tcsb_pkg::TCP_CONST_SUM;
        s2_valid_next   = s2_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_comb
    begin
        push_data          = s2_hdr_reg;
        push_data.ip_csum  = fold_csum(s2_ip_sum_reg);
        push_data.tcp_csum = fold_csum(s2_tcp_sum_reg);
    end
    assign push_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_hdr_reg      <= s1_hdr_next;
            s1_addr_sum_reg <= s1_addr_sum_next;
            s1_tcp_part_reg <= s1_tcp_part_next;
        end
        if (s2_adv)
        begin
            s2_hdr_reg     <= s2_hdr_next;
            s2_ip_sum_reg  <= s2_ip_sum_next;
            s2_tcp_sum_reg <= s2_tcp_sum_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcsb_queue.sv
// Short header queue between the front pipeline and the word serializer.
// Register-based ring of finished headers; depends on tcsb_pkg.
`default_nettype none

module tcsb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire tcsb_pkg::hdr_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output tcsb_pkg::hdr_t      pop_data,
    output tcsb_pkg::q_stat_t   stat
);

    tcsb_pkg::hdr_t                  entry_reg [tcsb_pkg::QUEUE_DEPTH];
    logic [tcsb_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tcsb_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tcsb_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            push;
    logic                            pop;

    function automatic logic [tcsb_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tcsb_pkg::QPTR_W-1:0] p);
        if (p == tcsb_pkg::QPTR_W'(tcsb_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + tcsb_pkg::QPTR_W'(1);
    endfunction

    assign stat.full  = (count_reg == tcsb_pkg::QCNT_W'(tcsb_pkg::QUEUE_DEPTH));
    assign stat.count = count_reg;
    assign push_ready = !stat.full;
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + tcsb_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - tcsb_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/tcsb_back.sv
// Word serializer: turns one finished header into ten big-endian words.
// Holds the current header and a registered output word; depends on tcsb_pkg.
`default_nettype none

module tcsb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire tcsb_pkg::hdr_t pop_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [31:0]         m_data,
    output logic                m_last
);

    tcsb_pkg::hdr_t             cur_reg, cur_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic [tcsb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic        load;
    logic        emit;
    logic        at_last;
    logic [31:0] word;

    assign load      = !out_valid_reg || m_ready;
    assign emit      = load && cur_valid_reg;
    assign at_last   = (idx_reg == tcsb_pkg::IDX_W'(tcsb_pkg::HDR_WORDS - 1));
    assign pop_ready = !cur_valid_reg || (emit && at_last);

    always_comb
    begin
        case (idx_reg)
            4'd0: word = {tcsb_pkg::VER_IHL, 8'h00, tcsb_pkg::TOTAL_LEN};
            4'd1: word = {cur_reg.ip_ident, 16'h0000};
            4'd2: word = {tcsb_pkg::TTL_VALUE, tcsb_pkg::PROTO_TCP, cur_reg.ip_csum};
            4'd3: word = cur_reg.source_addr;
            4'd4: word = cur_reg.dest_addr;
            4'd5: word = {cur_reg.source_tcp_port, cur_reg.dest_tcp_port};
            4'd6: word = cur_reg.seq_number;
            4'd7: word = cur_reg.ack_number;
            4'd8: word = {tcsb_pkg::DATA_OFS, cur_reg.flags, cur_reg.window};
            4'd9: word = {cur_reg.tcp_csum, 16'h0000};
            default: word = 32'd0;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop_ready && pop_valid)
        begin
            cur_next       = pop_data;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (emit && at_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + tcsb_pkg::IDX_W'(1);
        end

        out_valid_next = load ? cur_valid_reg : out_valid_reg;
        out_data_next  = emit ? word : out_data_reg;
        out_last_next  = emit ? at_last : out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign m_last  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/tcp_control_segment_builder.sv
// Top level of the TCP control segment builder: front pipeline, header queue, serializer.
// Depends on tcsb_pkg, tcsb_front, tcsb_queue and tcsb_back.
//
// Usage:
//   s_axis carries one request per word: tuser is the segment kind (ACK, FIN+ACK,
//   RST, plain), tdata holds addresses, ports, sequence/ack numbers and IP ident.
//   m_axis returns the 40-byte IPv4+TCP header as ten 32-bit big-endian words in
//   wire order; tlast marks the tenth word.
//   The first word of a request passes through the two checksum stages, the queue, the
//   serializer's header register and its output word register before it is valid.
//   Throughput: one word per clock on m_axis while m_axis_tready is high; the
//   single word-wide output channel sets that rate, and back-to-back requests
//   come out with no gap between them.
//   Up to five requests are buffered (two front stages, two queue entries, the one
//   being serialized); s_axis_tready drops only when all of them are full.
//   Reset clears all valid state: m_axis_tvalid is low and s_axis_tready is high
//   once rst_n is released. A stalled m_axis holds its word and fills the buffers.
`default_nettype none

module tcp_control_segment_builder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // source_addr, dest_addr, source_tcp_port, dest_tcp_port, seq_number,
    // ack_number, ip_ident
    input  wire logic [tcsb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // header_word
    output logic [tcsb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // last_word
    output logic                                  m_axis_tlast
);

    tcsb_pkg::req_t    req;
    tcsb_pkg::hdr_t    push_data;
    tcsb_pkg::hdr_t    pop_data;
    tcsb_pkg::q_stat_t q_stat;
    logic              push_valid;
    logic              push_ready;
    logic              pop_valid;
    logic              pop_ready;

    assign req.source_addr     = s_axis_tdata[31:0];
    assign req.dest_addr       = s_axis_tdata[63:32];
    assign req.source_tcp_port = s_axis_tdata[79:64];
    assign req.dest_tcp_port   = s_axis_tdata[95:80];
    assign req.seq_number      = s_axis_tdata[127:96];
    assign req.ack_number      = s_axis_tdata[159:128];
    assign req.ip_ident        = s_axis_tdata[175:160];

    tcsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_kind     (s_axis_tuser),
        .s_req      (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tcsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .stat       (q_stat)
    );

    tcsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= tcsb_pkg::QCNT_W'(tcsb_pkg::QUEUE_DEPTH))
        else $error("header queue count out of range");

    a_queue_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop_ready) |=> q_stat.full)
        else $error("header queue lost an entry while full");

    a_last_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[15:0] == 16'h0000))
        else $error("last header word has nonzero low half");

    a_next_starts_ip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
        |=> (!m_axis_tvalid || (m_axis_tdata == {tcsb_pkg::VER_IHL, 8'h00,
                                                  tcsb_pkg::TOTAL_LEN})))
        else $error("word after last is not the start of a header");

endmodule

`default_nettype wire

// File: dv/tcsb_header_checker.sv
// Scoreboard for the TCP control segment builder: predicts the ten header words of each
// accepted request and compares them with the words leaving m_axis.
// Depends on tcsb_pkg.

module tcsb_header_checker
    import tcsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     words_due,
    output int                     fail_count
);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } hdr_word_t;

    hdr_word_t header_queue[$];
    int        mismatches = 0;

    initial
    begin
        words_due  = 0;
        fail_count = 0;
    end

    function automatic logic [31:0] half_sum(input logic [31:0] w);
        return {16'h0, w[31:16]} + {16'h0, w[15:0]};
    endfunction

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'h0, s[31:16]} + {16'h0, s[15:0]};
        t = {16'h0, t[31:16]} + {16'h0, t[15:0]};
        return ~t[15:0];
    endfunction

    // tdata from the lowest bit: saddr, daddr, sport, dport, seq, ack, ident
    function automatic logic [9:0][31:0] build_segment_header(input kind_t kind,
                                                              input logic [175:0] d);
        logic [9:0][31:0] w;
        logic [31:0]      ack;
        logic [7:0]       flags;
        logic [15:0]      window;
        logic [31:0]      s;
        ack    = d[159:128];
        flags  = FLAG_NONE;
        window = 16'h0;
        case (kind)
            KIND_ACK: flags = FLAG_ACK;
            KIND_FIN:
            begin
                flags  = FLAG_FIN | FLAG_ACK;
                window = FIN_WINDOW;
            end
            KIND_RST:
            begin
                flags = FLAG_RST;
                ack   = 32'h0;
            end
            default: flags = FLAG_NONE;
        endcase
        w[0] = {VER_IHL, 8'h00, TOTAL_LEN};
        w[1] = {d[175:160], 16'h0};
        w[2] = {TTL_VALUE, PROTO_TCP, 16'h0};
        w[3] = d[31:0];
        w[4] = d[63:32];
        w[5] = {d[79:64], d[95:80]};
        w[6] = d[127:96];
        w[7] = ack;
        w[8] = {DATA_OFS, flags, window};
        s = half_sum(w[0]) + half_sum(w[1]) + half_sum(w[2]) + half_sum(w[3])
            + half_sum(w[4]);
        w[2][15:0] = ones_fold(s);
        // pseudo header: addresses, protocol, TCP length
        s = half_sum(w[3]) + half_sum(w[4]) + {24'h0, PROTO_TCP} + {16'h0, TCP_LEN}
            + half_sum(w[5]) + half_sum(w[6]) + half_sum(w[7]) + half_sum(w[8]);
        w[9] = {ones_fold(s), 16'h0};
        return w;
    endfunction

    always @(posedge clk)
    begin
        logic [9:0][31:0] hdr;
        hdr_word_t        exp_w;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (header_queue.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    exp_w = header_queue.pop_front();
                    if (m_axis_tdata !== exp_w.word)
                    begin
                        $display("%0t: header_word mismatch: expected %h, actual %h",
                                 $time, exp_w.word, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== exp_w.last)
                    begin
                        $display("%0t: last_word mismatch: expected %b, actual %b",
                                 $time, exp_w.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                hdr = build_segment_header(kind_t'(s_axis_tuser), s_axis_tdata);
                for (int k = 0; k < HDR_WORDS; k++)
                    header_queue.push_back('{word: hdr[k], last: (k == HDR_WORDS - 1)});
            end
        end
        words_due  <= header_queue.size();
        fail_count <= mismatches;
    end

endmodule

// File: dv/tb_tcp_control_segment_builder.sv
// Testbench top for the TCP control segment builder: drives requests in bursts, stalls
// the header stream, and reports the verdict. Depends on tcsb_pkg, tcsb_header_checker
// and the block's RTL.

module tb_tcp_control_segment_builder;
    import tcsb_pkg::*;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = KIND_ACK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    int                     words_due;
    int                     fail_count;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always #1 clk = ~clk;

    tcp_control_segment_builder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    tcsb_header_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .words_due     (words_due),
        .fail_count    (fail_count)
    );

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= rx_left[2];
        endcase
    end

    function automatic logic [175:0] pack_request(input logic [31:0] saddr,
                                                  input logic [31:0] daddr,
                                                  input logic [15:0] sport,
                                                  input logic [15:0] dport,
                                                  input logic [31:0] seq,
                                                  input logic [31:0] ack,
                                                  input logic [15:0] ident);
        return {ident, ack, seq, dport, sport, daddr, saddr};
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(input kind_t kind, input logic [175:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                              16'($urandom)};
            s_axis_tuser  <= 2'($urandom_range(0, 3));
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_headers();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        kind_t kinds[4];
        int    burst_left;
        kinds = '{KIND_ACK, KIND_FIN, KIND_RST, KIND_PLAIN};
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every kind with all-zero, all-one and alternating fields
        foreach (kinds[i])
        begin
            push_request(kinds[i], '0);
            push_request(kinds[i], '1);
            push_request(kinds[i], {22{8'haa}});
            push_request(kinds[i], {22{8'h55}});
        end
        push_request(KIND_RST, pack_request(32'h0a00_0001, 32'h0a00_0002, 16'd80,
                                            16'd49152, 32'h1234_5678, 32'hdead_beef,
                                            16'h0001));
        push_request(KIND_FIN, pack_request(32'hc0a8_0101, 32'hc0a8_01fe, 16'hffff,
                                            16'h0000, 32'hffff_ffff, 32'h0000_0001,
                                            16'hffff));
        drain_headers();

        for (int n = 0; n < 300; n++)
        begin
            if (n == 100 || n == 200)
                drain_headers();
            if (burst_left == 0)
            begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 16);
            end
            push_request(kind_t'($urandom_range(0, 3)),
                         pack_request(pick_value(), pick_value(), 16'(pick_value()),
                                      16'(pick_value()), pick_value(), pick_value(),
                                      16'(pick_value())));
            burst_left--;
        end

        drain_headers();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tcp_control_segment_builder verification clean");
        else
            $display("tcp_control_segment_builder verification failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tcp_control_segment_builder verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/tcsb_pkg.sv
rtl/tcsb_front.sv
rtl/tcsb_queue.sv
rtl/tcsb_back.sv
rtl/tcp_control_segment_builder.sv
dv/tcsb_header_checker.sv
dv/tb_tcp_control_segment_builder.sv
